// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the port checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masked
`define SGA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define SGA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sga_pkg.sv =====
// constants and helpers for the symmetric gram accumulator
// no dependencies
package sga_pkg;
  localparam int MAX_COLS   = 8;
  localparam int COL_W      = 3;
  localparam int NCOL_W     = 4;
  localparam int ELEM_W     = 16;
  localparam int ACC_W      = 64;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam logic [MODE_W-1:0] MODE_ATA  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ATWA = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUM  = 2'd2;

  // start of row i in the packed lower triangle
  function automatic logic [5:0] tri_base(input logic [COL_W-1:0] i);
    logic [6:0] prod;
    prod = {4'd0, i} * ({4'd0, i} + 7'd1);
    return prod[6:1];
  endfunction
endpackage

// ===== hw/rtl/sga_if.sv =====
// input and result channels of the symmetric gram accumulator
// depends on sga_pkg
interface sga_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sga_pkg::ELEM_W-1:0]   a_value;
  logic signed [sga_pkg::ELEM_W-1:0]   b_value;
  logic        [sga_pkg::ELEM_W-1:0]   row_weight;
  logic                                final_row;
  modport source (output valid, a_value, b_value, row_weight, final_row, input ready);
  modport sink   (input valid, a_value, b_value, row_weight, final_row, output ready);
endinterface

interface sga_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sga_pkg::ACC_W-1:0]    result_value;
  logic        [sga_pkg::COL_W-1:0]    out_row;
  logic        [sga_pkg::COL_W-1:0]    out_col;
  logic                                last_entry;
  modport source (output valid, result_value, out_row, out_col, last_entry, input ready);
  modport sink   (input valid, result_value, out_row, out_col, last_entry, output ready);
endinterface

// ===== hw/rtl/sga_front.sv =====
// front part: row gathering, pushes one row job per row end
// depends on sga_pkg and sga_if
module sga_front #(
  parameter int MAX_COLS = sga_pkg::MAX_COLS,
  parameter int JOB_W    = MAX_COLS * 2 * sga_pkg::ELEM_W + sga_pkg::ELEM_W + 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  sga_in_if.sink                    in_if,
  input  logic [sga_pkg::NCOL_W-1:0] n_cols,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [JOB_W-1:0]          q_data
);
  localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [MAX_COLS-1:0][sga_pkg::ELEM_W-1:0] a_st_r, b_st_r, a_nxt, b_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic              acc;
  logic              row_end;
  logic [sga_pkg::NCOL_W:0] pos_inc;

  assign in_if.ready = !q_full;
  assign acc         = in_if.valid && in_if.ready;
  assign pos_inc     = (sga_pkg::NCOL_W+1)'(pos_r) + 1'b1;
  assign row_end     = pos_inc >= {1'b0, n_cols};

  always_comb begin
    a_nxt = a_st_r;
    b_nxt = b_st_r;
    a_nxt[pos_r] = in_if.a_value;
    b_nxt[pos_r] = in_if.b_value;
    pos_nxt = row_end ? '0 : pos_r + 1'b1;
  end

  assign q_push = acc && row_end;
  assign q_data = {in_if.final_row, in_if.row_weight, b_nxt, a_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (acc) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_st_r <= a_nxt;
      b_st_r <= b_nxt;
    end
  end
endmodule

// ===== hw/rtl/sga_queue.sv =====
// two-entry job queue between front and back
// depends on nothing
module sga_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  logic [1:0][WIDTH-1:0] mem_r;
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end
endmodule

// ===== hw/rtl/sga_back.sv =====
// back part: triangle multiply-accumulate and matrix emission
// depends on sga_pkg and sga_if
module sga_back #(
  parameter int MAX_COLS = sga_pkg::MAX_COLS,
  parameter int JOB_W    = MAX_COLS * 2 * sga_pkg::ELEM_W + sga_pkg::ELEM_W + 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [sga_pkg::NCOL_W-1:0] n_cols,
  input  logic [sga_pkg::MODE_W-1:0] mode,
  input  logic                       q_empty,
  input  logic [JOB_W-1:0]           q_data,
  output logic                       q_pop,
  sga_out_if.source                  out_if
);
  localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int TRI   = MAX_COLS * (MAX_COLS + 1) / 2;
  localparam int TRI_W = (TRI > 1) ? $clog2(TRI) : 1;
  localparam int EW    = sga_pkg::ELEM_W;
  localparam int AW    = sga_pkg::ACC_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_TERM = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_ERD  = 3'd4;
  localparam logic [2:0] S_EOUT = 3'd5;

  logic [2:0] st_r;
  logic [MAX_COLS-1:0][EW-1:0] a_v, b_v;
  logic [EW-1:0]     w_v;
  logic              last_v;
  logic [JOB_W-1:0]  job_r;
  logic [IDX_W-1:0]  i_r, j_r, r_r, c_r;
  logic [TRI_W-1:0]  idx_r, eaddr;
  logic signed [2*EW-1:0] p1_r, p2_r;
  logic signed [AW-1:0]   term_r, sum_sat;
  logic signed [AW:0]     sum_w;
  logic signed [3*EW:0]   wprod;
  logic signed [AW-1:0]   wprod_x;
  logic [AW-1:0]     mem [TRI];
  logic [AW-1:0]     rd_q_r;
  logic              rd_ok_r;
  logic [TRI-1:0]    tval_r;
  logic signed [AW-1:0] base_val;
  logic [IDX_W-1:0]  lo, hi, n_last;
  logic              out_free, emit_last;
  logic signed [AW-1:0] res_r;
  logic [sga_pkg::COL_W-1:0] orow_r, ocol_r;
  logic              olast_r, ov_r;

  assign a_v    = job_r[MAX_COLS*EW-1:0];
  assign b_v    = job_r[2*MAX_COLS*EW-1:MAX_COLS*EW];
  assign w_v    = job_r[2*MAX_COLS*EW +: EW];
  assign last_v = job_r[JOB_W-1];
  assign n_last = IDX_W'(n_cols - 1'b1);

  assign hi    = (r_r >= c_r) ? r_r : c_r;
  assign lo    = (r_r >= c_r) ? c_r : r_r;
  assign eaddr = TRI_W'(sga_pkg::tri_base(sga_pkg::COL_W'(hi))) + TRI_W'(lo);

  assign wprod   = p1_r * $signed({1'b0, w_v});
  assign wprod_x = {{(AW-3*EW-1){wprod[3*EW]}}, wprod};
  assign base_val = rd_ok_r ? $signed(rd_q_r) : '0;
  assign sum_w   = {base_val[AW-1], base_val} + {term_r[AW-1], term_r};
  always_comb begin
    if (sum_w[AW] != sum_w[AW-1]) begin
      sum_sat = sum_w[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      sum_sat = sum_w[AW-1:0];
    end
  end

  assign out_free  = !ov_r || out_if.ready;
  assign emit_last = (r_r == n_last) && (c_r == n_last);
  assign q_pop     = (st_r == S_IDLE) && !q_empty;

  assign out_if.valid        = ov_r;
  assign out_if.result_value = res_r;
  assign out_if.out_row      = orow_r;
  assign out_if.out_col      = ocol_r;
  assign out_if.last_entry   = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      tval_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (st_r == S_EOUT && out_free) begin
        ov_r <= 1'b1;
      end else if (out_if.ready) begin
        ov_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (!q_empty) st_r <= S_MUL;
        end
        S_MUL:  st_r <= S_TERM;
        S_TERM: st_r <= S_ACC;
        S_ACC: begin
          tval_r[idx_r] <= 1'b1;
          if (j_r == i_r && i_r == n_last) begin
            st_r <= last_v ? S_ERD : S_IDLE;
          end else begin
            st_r <= S_MUL;
          end
        end
        S_ERD:  st_r <= S_EOUT;
        S_EOUT: begin
          if (out_free) begin
            if (emit_last) begin
              tval_r <= '0;
              st_r   <= S_IDLE;
            end else begin
              st_r <= S_ERD;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        job_r <= q_data;
        i_r   <= '0;
        j_r   <= '0;
        idx_r <= '0;
        r_r   <= '0;
        c_r   <= '0;
      end
      S_MUL: begin
        if (mode == sga_pkg::MODE_SUM) begin
          p1_r <= $signed(a_v[i_r]) * $signed(b_v[j_r]);
          p2_r <= $signed(b_v[i_r]) * $signed(a_v[j_r]);
        end else begin
          p1_r <= $signed(a_v[i_r]) * $signed(a_v[j_r]);
          p2_r <= '0;
        end
        rd_q_r  <= mem[idx_r];
        rd_ok_r <= tval_r[idx_r];
      end
      S_TERM: begin
        if (mode == sga_pkg::MODE_ATWA) begin
          term_r <= wprod_x >>> EW-1;
        end else begin
          term_r <= AW'(p1_r) + AW'(p2_r);
        end
      end
      S_ACC: begin
        mem[idx_r] <= sum_sat;
        idx_r <= idx_r + 1'b1;
        if (j_r == i_r) begin
          i_r <= i_r + 1'b1;
          j_r <= '0;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      S_ERD: begin
        rd_q_r  <= mem[eaddr];
        rd_ok_r <= tval_r[eaddr];
      end
      S_EOUT: begin
        if (out_free) begin
          res_r   <= base_val;
          orow_r  <= sga_pkg::COL_W'(r_r);
          ocol_r  <= sga_pkg::COL_W'(c_r);
          olast_r <= emit_last;
          if (c_r == n_last) begin
            c_r <= '0;
            r_r <= r_r + 1'b1;
          end else begin
            c_r <= c_r + 1'b1;
          end
        end
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
  end
endmodule

// ===== hw/rtl/symmetric_gram_accumulator.sv =====
// top level of the symmetric gram accumulator: config registers, front, queue, back
// depends on sga_pkg, sga_if, sga_front, sga_queue, sga_back
//
//   channel  | dir | handshake      | payload
//   in_if    | in  | valid/ready    | a_value b_value row_weight final_row
//   out_if   | out | valid/ready    | result_value out_row out_col last_entry
//   cfg      | in  | cfg_we         | cfg_index cfg_data
//
// an element that does not end a row is only stored; a row end queues a job
// the back runs S_MUL, S_TERM, S_ACC per triangle entry, n(n+1)/2 entries per row,
// through one shared multiply-accumulate unit and a single-port sum memory
// emission runs S_ERD and S_EOUT per entry and holds in S_EOUT on output stall
// synchronous reset clears control state and the sum valid flags
// the two-entry job queue lets the front take elements while the back is busy
module symmetric_gram_accumulator #(
  parameter int MAX_COLS = sga_pkg::MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sga_in_if.sink                        in_if,
  sga_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [sga_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sga_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int JOB_W = MAX_COLS * 2 * sga_pkg::ELEM_W + sga_pkg::ELEM_W + 1;

  logic [sga_pkg::MODE_W-1:0] mode_r, mode_eff;
  logic [sga_pkg::NCOL_W-1:0] cols_r, n_cols;
  logic             q_push, q_pop, q_full, q_empty;
  logic [JOB_W-1:0] q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sga_pkg::MODE_ATA;
      cols_r <= sga_pkg::NCOL_W'(MAX_COLS);
    end else if (cfg_we) begin
      if (cfg_index == sga_pkg::REG_MODE) mode_r <= cfg_data[sga_pkg::MODE_W-1:0];
      if (cfg_index == sga_pkg::REG_COLS) cols_r <= cfg_data[sga_pkg::NCOL_W-1:0];
    end
  end

  assign mode_eff = (mode_r == sga_pkg::MODE_ATWA || mode_r == sga_pkg::MODE_SUM)
                    ? mode_r : sga_pkg::MODE_ATA;

  always_comb begin
    priority if (cols_r == '0) begin
      n_cols = sga_pkg::NCOL_W'(1);
    end else if (cols_r > sga_pkg::NCOL_W'(MAX_COLS)) begin
      n_cols = sga_pkg::NCOL_W'(MAX_COLS);
    end else begin
      n_cols = cols_r;
    end
  end

  sga_front #(.MAX_COLS(MAX_COLS), .JOB_W(JOB_W)) u_front (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .n_cols(n_cols),
    .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  sga_queue #(.WIDTH(JOB_W)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in),
    .pop(q_pop), .pop_data(q_out), .full(q_full), .empty(q_empty)
  );

  sga_back #(.MAX_COLS(MAX_COLS), .JOB_W(JOB_W)) u_back (
    .clk(clk), .rst_n(rst_n), .n_cols(n_cols), .mode(mode_eff),
    .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop), .out_if(out_if)
  );
endmodule

// ===== hw/rtl/sga_checker.sv =====
// port-level checks for the symmetric gram accumulator, bound to the top level
// depends on assert_macros.svh and symmetric_gram_accumulator
`include "assert_macros.svh"
module sga_port_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [sga_pkg::ACC_W-1:0]       out_value,
  input logic [sga_pkg::COL_W-1:0]       out_r,
  input logic [sga_pkg::COL_W-1:0]       out_c,
  input logic                            out_last
);
  `SGA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  `SGA_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_value), "result changed while stalled")
  `SGA_ASSERT_NOW(a_last_diag, clk, rst_n, out_valid && out_last, out_r == out_c, "last entry off the diagonal")
  `SGA_ASSERT_NEXT(a_gap_after_last, clk, rst_n, out_valid && out_ready && out_last, !out_valid, "result right after last entry")
endmodule

bind symmetric_gram_accumulator sga_port_checker u_sga_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_value(out_if.result_value), .out_r(out_if.out_row), .out_c(out_if.out_col),
  .out_last(out_if.last_entry)
);
